/* src/bf16eu_pkg.sv */
package bf16eu_pkg;

  // Command codes carried by each input word.
  typedef enum logic [1:0] {
    CMD_GET   = 2'd0,
    CMD_SET   = 2'd1,
    CMD_SCALE = 2'd2,
    CMD_POW   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CLS_FINITE = 2'd0,
    CLS_ZERO   = 2'd1,
    CLS_INFNAN = 2'd2,
    CLS_NONE   = 2'd3
  } cls_t;

  localparam logic [15:0] SIGN_BIT  = 16'h8000;
  localparam logic [15:0] EXP_FIELD = 16'h7F80;
  localparam logic [7:0]  EXP_ALL   = 8'hFF;
  localparam logic [7:0]  HIDDEN    = 8'h80;
  localparam int          BIAS      = 127;

  // Values carried from the first stage to the second.
  typedef struct packed {
    logic        vld;
    cmd_t        cmd;
    logic [15:0] w;
    logic [9:0]  e;       // exponent clamped to [-300, 300]
    logic        e_ge128;
    logic        e_lem127;
    logic [2:0]  p;       // leading one position of the significand
    logic [7:0]  sig;
  } st1_t;

  // Values carried from the second stage to the third.
  typedef struct packed {
    logic        vld;
    cmd_t        cmd;
    logic [15:0] w;
    logic [9:0]  e;
    logic        e_ge128;
    logic        e_lem127;
    logic [2:0]  p;
    logic [7:0]  sig;
    logic [10:0] ex;      // sig * 2^ex is the scaled value
    logic [10:0] u;       // unbiased exponent of the scaled value
  } st2_t;

endpackage

/* src/bfloat16_exponent_unit_top.sv */
// An accepted input word is registered in s1_r, then s2_r, then res_r, which drives its result word.
// Throughput: one word per cycle; the three-stage pipeline holds as a whole on out_stall.
// The stages are leading-one detect, exponent arithmetic, then shift, round and select.
// Reset: rst_n, synchronous and active low, clears the stage valid bits only.
module bfloat16_exponent_unit_top (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_command,
  input  logic [15:0]             in_operand_bits,
  input  logic signed [15:0]      in_exponent_in,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [15:0]             out_result_bits,
  output logic signed [7:0]       out_exponent_out,
  output logic [1:0]              out_exponent_class
);
  import bf16eu_pkg::*;

  st1_t        s1_r, s1_nxt;
  st2_t        s2_r, s2_nxt;
  logic        v3_r;
  logic [15:0] res_r, res_nxt;
  logic [7:0]  eo_r, eo_nxt;
  logic [1:0]  cls_r, cls_nxt;
  logic        adv;

  // The pipeline moves when the output is empty or being taken.
  assign adv      = !v3_r || !out_stall;
  assign in_stall = !adv;

  // Stage one: clamp the exponent and find the leading one.
  always_comb begin
    logic [7:0] be;
    s1_nxt          = '0;
    be              = in_operand_bits[14:7];
    s1_nxt.vld      = in_valid;
    s1_nxt.cmd      = cmd_t'(in_command);
    s1_nxt.w        = in_operand_bits;
    s1_nxt.e_ge128  = in_exponent_in >= 16'sd128;
    s1_nxt.e_lem127 = in_exponent_in <= -16'sd127;
    if (in_exponent_in > 16'sd300)       s1_nxt.e = 10'sd300;
    else if (in_exponent_in < -16'sd300) s1_nxt.e = -10'sd300;
    else                                 s1_nxt.e = in_exponent_in[9:0];
    s1_nxt.sig = (be == 8'd0) ? {1'b0, in_operand_bits[6:0]}
                              : (HIDDEN | {1'b0, in_operand_bits[6:0]});
    s1_nxt.p = 3'd0;
    for (int i = 1; i < 8; i++) begin
      if (s1_nxt.sig[i]) s1_nxt.p = 3'(i);
    end
  end

  // Stage two: exponent of the scaled value.
  always_comb begin
    logic [10:0] be1;
    be1         = (s1_r.w[14:7] == 8'd0) ? 11'd1 : {3'd0, s1_r.w[14:7]};
    s2_nxt.vld      = s1_r.vld;
    s2_nxt.cmd      = s1_r.cmd;
    s2_nxt.w        = s1_r.w;
    s2_nxt.e        = s1_r.e;
    s2_nxt.e_ge128  = s1_r.e_ge128;
    s2_nxt.e_lem127 = s1_r.e_lem127;
    s2_nxt.p        = s1_r.p;
    s2_nxt.sig      = s1_r.sig;
    s2_nxt.ex       = be1 - 11'd134 + {s1_r.e[9], s1_r.e};
    s2_nxt.u        = s2_nxt.ex + {8'd0, s1_r.p};
  end

  // Stage three: shift, round and choose the result for the command.
  always_comb begin
    logic [15:0] w, s;
    logic [6:0]  m;
    logic        isnan, isinf, iszero;
    logic signed [10:0] es, ex, u, k, sh;
    logic [15:0] q, rem, half, t;
    logic [3:0]  r;
    w = s2_r.w;
    s = w & SIGN_BIT;
    m = w[6:0];
    isinf  = (w[14:7] == EXP_ALL) && m == 7'd0;
    isnan  = (w[14:7] == EXP_ALL) && m != 7'd0;
    iszero = w[14:0] == 15'd0;
    es = {s2_r.e[9], s2_r.e};
    ex = s2_r.ex;
    u  = s2_r.u;
    k  = ex + 11'sd133;
    r  = 4'd0;
    q = '0; rem = '0; half = '0; t = '0;
    sh = -11'sd126 - es;
    res_nxt = '0;
    eo_nxt  = '0;
    cls_nxt = CLS_FINITE;
    case (s2_r.cmd)
      CMD_GET: begin
        if (w[14:7] == 8'd0) begin
          if (m != 7'd0) eo_nxt = 8'(-126);
          else           cls_nxt = CLS_ZERO;
        end else if (w[14:7] == EXP_ALL) begin
          cls_nxt = CLS_INFNAN;
        end else begin
          eo_nxt = w[14:7] - 8'(BIAS);
        end
      end
      CMD_SET: begin
        if (isnan || (isinf && s2_r.e_ge128)) res_nxt = w;
        else if (isinf && s2_r.e_lem127) res_nxt = s;
        else if (isinf) res_nxt = s | {1'b0, s2_r.e[7:0] + 8'(BIAS), 7'd0};
        else if (s2_r.e_ge128) res_nxt = s | EXP_FIELD;
        else if (iszero) res_nxt = s;
        else if (es >= -11'sd126)
          res_nxt = s | {1'b0, s2_r.e[7:0] + 8'(BIAS), m};
        else if (sh >= 11'sd8 || s2_r.e_lem127 && sh >= 11'sd8) res_nxt = s;
        else res_nxt = s | {9'd0, 7'((({1'b1, m}) >> sh[2:0]))};
      end
      CMD_SCALE: begin
        if (isnan || isinf || iszero) res_nxt = w;
        else if (u > 11'sd127) res_nxt = s | EXP_FIELD;
        else if (u >= -11'sd126)
          res_nxt = s | {1'b0, 8'(u[7:0] + 8'(BIAS)),
                         7'(s2_r.sig << (3'd7 - s2_r.p))};
        else if (k >= 11'sd0) res_nxt = s | {8'd0, 8'(s2_r.sig << k[2:0])};
        else if (k < -11'sd9) res_nxt = s;
        else begin
          r    = 4'(-k);
          q    = {8'd0, s2_r.sig} >> r;
          t    = (16'd1 << r) - 16'd1;
          rem  = {8'd0, s2_r.sig} & t;
          half = 16'd1 << (r - 4'd1);
          if (rem > half || (rem == half && q[0])) q = q + 16'd1;
          res_nxt = s | q;
        end
      end
      default: begin
        if (es > 11'sd127) res_nxt = EXP_FIELD;
        else if (es < -11'sd133) res_nxt = '0;
        else if (es < -11'sd126) res_nxt = 16'd1 << (es[2:0] + 3'd5);
        else res_nxt = {1'b0, s2_r.e[7:0] + 8'(BIAS), 7'd0};
      end
    endcase
  end

  // Pipeline registers; valid bits take reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld <= 1'b0;
      s2_r.vld <= 1'b0;
      v3_r     <= 1'b0;
    end else if (adv) begin
      s1_r  <= s1_nxt;
      s2_r  <= s2_nxt;
      v3_r  <= s2_r.vld;
      res_r <= res_nxt;
      eo_r  <= eo_nxt;
      cls_r <= cls_nxt;
    end
  end

  assign out_valid          = v3_r;
  assign out_result_bits    = res_r;
  assign out_exponent_out   = eo_r;
  assign out_exponent_class = cls_r;

  // A word waiting at the output must not be overwritten.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_bits))
    else $error("output word lost under stall");
  // The input is held off only while a finished word waits at the output.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without cause");
  // The class is never the unused code.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_exponent_class != CLS_NONE)
    else $error("unused class code");

endmodule
